// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge of clk and switched off during reset.
`define CHECK_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: when cond holds at an edge, res must hold at the same edge.
`define CHECK_IMPL(label, cond, res, msg) \
  `CHECK_CLKD(label, (cond) |-> (res), msg)

`endif

// ===== rtl/trs_pkg.sv =====
`default_nettype none

package trs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PREDICTION_HOLD = 3'd0;
  localparam logic [2:0] REG_SCAN_PERIOD     = 3'd1;
  localparam logic [2:0] REG_YAW_HALF_SPAN   = 3'd2;
  localparam logic [2:0] REG_YAW_STEP        = 3'd3;
  localparam logic [2:0] REG_PITCH_HALF_SPAN = 3'd4;
  localparam logic [2:0] REG_PITCH_STEP      = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_TRACK   = 2'd0,
    MODE_PREDICT = 2'd1,
    MODE_SCAN    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_UPDATE_SEEN = 2'd0,
    OP_UPDATE_LOST = 2'd1,
    OP_COMMIT      = 2'd2
  } item_op_t;

  typedef struct packed {
    item_op_t           op;
    logic [31:0]        now_time;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [16:0] yaw_done_pulses;
    logic               yaw_taken;
    logic signed [16:0] pitch_done_pulses;
    logic               pitch_taken;
  } item_t;

  typedef struct packed {
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic               forward;
    logic signed [16:0] command;
  } axis_res_t;

  // One scan step on one axis: turn round at the span edges, then clip the
  // step to the distance left to the edge in the direction of travel.
  function automatic axis_res_t axis_step(input logic signed [31:0] pos,
                                          input logic [15:0] half,
                                          input logic [15:0] step,
                                          input logic forward);
    logic signed [33:0] p;
    logic signed [33:0] h;
    logic signed [33:0] s;
    logic signed [33:0] rem;
    logic signed [33:0] c;
    axis_res_t          res;
    p = {{2{pos[31]}}, pos};
    h = {18'd0, half};
    s = {18'd0, step};
    res.forward = forward;
    if (p >= h) begin
      res.forward = 1'b0;
    end else if (p <= -h) begin
      res.forward = 1'b1;
    end
    if (res.forward) begin
      rem = h - p;
      c = (s > rem) ? rem : s;
    end else begin
      rem = -h - p;
      c = (-s < rem) ? rem : -s;
    end
    res.command = c[16:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trs_front.sv =====
`default_nettype none

module trs_front
  import trs_pkg::*;
(
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic [31:0]        now_time,
  input  wire logic               target_seen,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [15:0] offset_y,
  input  wire logic signed [16:0] yaw_done_pulses,
  input  wire logic               yaw_taken,
  input  wire logic signed [16:0] pitch_done_pulses,
  input  wire logic               pitch_taken,
  input  wire queue_status_t      q_status,
  output logic                    push,
  output item_t                   push_item
);

  // The item is taken whenever the queue has room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    if (kind) begin
      push_item.op = OP_COMMIT;
    end else if (target_seen) begin
      push_item.op = OP_UPDATE_SEEN;
    end else begin
      push_item.op = OP_UPDATE_LOST;
    end
    push_item.now_time          = now_time;
    push_item.offset_x          = offset_x;
    push_item.offset_y          = offset_y;
    push_item.yaw_done_pulses   = yaw_done_pulses;
    push_item.yaw_taken         = yaw_taken;
    push_item.pitch_done_pulses = pitch_done_pulses;
    push_item.pitch_taken       = pitch_taken;
  end

endmodule

`default_nettype wire

// ===== rtl/trs_queue.sv =====
`default_nettype none

module trs_queue
  import trs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output logic       q_valid,
  output item_t      q_item,
  output queue_status_t q_status
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign q_valid        = (count != '0);
  assign q_item         = slots[rd_ptr];
  assign q_status.full  = (count == CntW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/trs_back.sv =====
`default_nettype none

module trs_back
  import trs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               q_valid,
  input  wire item_t              q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              mode_now,
  output logic                    use_track,
  output logic                    reset_track,
  output logic                    stop_track,
  output logic signed [15:0]      track_x,
  output logic signed [15:0]      track_y,
  output logic signed [16:0]      yaw_command,
  output logic signed [16:0]      pitch_command
);

  logic [15:0] prediction_hold;
  logic [15:0] scan_period;
  logic [15:0] yaw_half_span;
  logic [15:0] yaw_step;
  logic [15:0] pitch_half_span;
  logic [15:0] pitch_step;

  mode_t              mode, mode_next;
  logic [31:0]        lost_time, lost_time_next;
  logic [31:0]        yaw_last, yaw_last_next;
  logic [31:0]        pitch_last, pitch_last_next;
  logic signed [15:0] held_x, held_x_next;
  logic signed [15:0] held_y, held_y_next;
  logic signed [31:0] yaw_pos, yaw_pos_next;
  logic signed [31:0] pitch_pos, pitch_pos_next;
  logic               yaw_fwd, yaw_fwd_next;
  logic               pitch_fwd, pitch_fwd_next;
  logic               hist_valid, hist_valid_next;

  logic               res_load;
  mode_t              res_mode, res_mode_next;
  logic               res_use, res_use_next;
  logic               res_reset, res_reset_next;
  logic               res_stop, res_stop_next;
  logic signed [15:0] res_x, res_x_next;
  logic signed [15:0] res_y, res_y_next;
  logic signed [16:0] res_yaw, res_yaw_next;
  logic signed [16:0] res_pitch, res_pitch_next;

  mode_t       eff_mode;
  logic [31:0] eff_lost;
  logic [31:0] since_lost;
  logic [31:0] yaw_elapsed;
  logic [31:0] pitch_elapsed;
  axis_res_t   yaw_res;
  axis_res_t   pitch_res;

  // A commit gives no result, so it may run while a result is still waiting.
  assign pop = q_valid && ((q_item.op == OP_COMMIT) || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      prediction_hold <= '0;
      scan_period     <= '0;
      yaw_half_span   <= '0;
      yaw_step        <= '0;
      pitch_half_span <= '0;
      pitch_step      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREDICTION_HOLD: prediction_hold <= cfg_data;
        REG_SCAN_PERIOD:     scan_period     <= cfg_data;
        REG_YAW_HALF_SPAN:   yaw_half_span   <= cfg_data;
        REG_YAW_STEP:        yaw_step        <= cfg_data;
        REG_PITCH_HALF_SPAN: pitch_half_span <= cfg_data;
        REG_PITCH_STEP:      pitch_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_TRACK;
      lost_time  <= '0;
      yaw_last   <= '0;
      pitch_last <= '0;
      held_x     <= '0;
      held_y     <= '0;
      yaw_pos    <= '0;
      pitch_pos  <= '0;
      yaw_fwd    <= 1'b1;
      pitch_fwd  <= 1'b1;
      hist_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mode       <= mode_next;
      lost_time  <= lost_time_next;
      yaw_last   <= yaw_last_next;
      pitch_last <= pitch_last_next;
      held_x     <= held_x_next;
      held_y     <= held_y_next;
      yaw_pos    <= yaw_pos_next;
      pitch_pos  <= pitch_pos_next;
      yaw_fwd    <= yaw_fwd_next;
      pitch_fwd  <= pitch_fwd_next;
      hist_valid <= hist_valid_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_mode  <= res_mode_next;
      res_use   <= res_use_next;
      res_reset <= res_reset_next;
      res_stop  <= res_stop_next;
      res_x     <= res_x_next;
      res_y     <= res_y_next;
      res_yaw   <= res_yaw_next;
      res_pitch <= res_pitch_next;
    end
  end

  always_comb begin
    yaw_elapsed   = q_item.now_time - yaw_last;
    pitch_elapsed = q_item.now_time - pitch_last;
    yaw_res   = axis_step(yaw_pos, yaw_half_span, yaw_step, yaw_fwd);
    pitch_res = axis_step(pitch_pos, pitch_half_span, pitch_step, pitch_fwd);

    mode_next       = mode;
    lost_time_next  = lost_time;
    yaw_last_next   = yaw_last;
    pitch_last_next = pitch_last;
    held_x_next     = held_x;
    held_y_next     = held_y;
    yaw_pos_next    = yaw_pos;
    pitch_pos_next  = pitch_pos;
    yaw_fwd_next    = yaw_fwd;
    pitch_fwd_next  = pitch_fwd;
    hist_valid_next = hist_valid;

    res_load       = 1'b0;
    res_mode_next  = MODE_SCAN;
    res_use_next   = 1'b0;
    res_reset_next = 1'b0;
    res_stop_next  = 1'b0;
    res_x_next     = '0;
    res_y_next     = '0;
    res_yaw_next   = '0;
    res_pitch_next = '0;

    // A loss seen while tracking starts the hold clock at this update.
    eff_mode = mode;
    eff_lost = lost_time;
    if (mode == MODE_TRACK) begin
      eff_mode = MODE_PREDICT;
      eff_lost = q_item.now_time;
    end
    since_lost = q_item.now_time - eff_lost;

    if (pop) begin
      unique case (q_item.op)
        OP_COMMIT: begin
          if (mode == MODE_SCAN) begin
            if (q_item.yaw_taken) begin
              yaw_pos_next = yaw_pos + {{15{q_item.yaw_done_pulses[16]}},
                                        q_item.yaw_done_pulses};
              yaw_last_next = q_item.now_time;
            end
            if (q_item.pitch_taken) begin
              pitch_pos_next = pitch_pos + {{15{q_item.pitch_done_pulses[16]}},
                                            q_item.pitch_done_pulses};
              pitch_last_next = q_item.now_time;
            end
          end
        end
        OP_UPDATE_SEEN: begin
          mode_next       = MODE_TRACK;
          held_x_next     = q_item.offset_x;
          held_y_next     = q_item.offset_y;
          hist_valid_next = 1'b1;
          res_load        = 1'b1;
          res_mode_next   = MODE_TRACK;
          res_use_next    = 1'b1;
          res_reset_next  = (mode != MODE_TRACK);
          res_stop_next   = (mode == MODE_SCAN);
          res_x_next      = q_item.offset_x;
          res_y_next      = q_item.offset_y;
        end
        OP_UPDATE_LOST: begin
          res_load       = 1'b1;
          lost_time_next = eff_lost;
          if (eff_mode == MODE_PREDICT) begin
            if (hist_valid && (since_lost < {16'd0, prediction_hold})) begin
              mode_next     = MODE_PREDICT;
              res_mode_next = MODE_PREDICT;
              res_use_next  = 1'b1;
              res_x_next    = held_x;
              res_y_next    = held_y;
            end else begin
              mode_next       = MODE_SCAN;
              yaw_pos_next    = '0;
              pitch_pos_next  = '0;
              yaw_fwd_next    = 1'b1;
              pitch_fwd_next  = 1'b1;
              yaw_last_next   = q_item.now_time;
              pitch_last_next = q_item.now_time;
              res_stop_next   = 1'b1;
            end
          end else begin
            if (yaw_elapsed >= {16'd0, scan_period}) begin
              yaw_fwd_next = yaw_res.forward;
              res_yaw_next = yaw_res.command;
            end
            if (pitch_elapsed >= {16'd0, scan_period}) begin
              pitch_fwd_next = pitch_res.forward;
              res_pitch_next = pitch_res.command;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign mode_now      = 2'(res_mode);
  assign use_track     = res_use;
  assign reset_track   = res_reset;
  assign stop_track    = res_stop;
  assign track_x       = res_x;
  assign track_y       = res_y;
  assign yaw_command   = res_yaw;
  assign pitch_command = res_pitch;

endmodule

`default_nettype wire

// ===== rtl/target_loss_recovery_scanner.sv =====
// An accepted update item passes through the queue into the output register.
// Throughput: one item per cycle unless a waiting result is stalled.
// Input stall rises only when the two-entry queue is full.
// Reset (rst, synchronous, active high) empties the queue and output stage, sets
// tracking mode, clears times, offsets and positions, sets both axes forward and
// zeroes all configuration registers. No clearing pass is needed.
`default_nettype none

module target_loss_recovery_scanner
  import trs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write port.
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // Input channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic [31:0]        now_time,
  input  wire logic               target_seen,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [15:0] offset_y,
  input  wire logic signed [16:0] yaw_done_pulses,
  input  wire logic               yaw_taken,
  input  wire logic signed [16:0] pitch_done_pulses,
  input  wire logic               pitch_taken,
  // Output channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              mode_now,
  output logic                    use_track,
  output logic                    reset_track,
  output logic                    stop_track,
  output logic signed [15:0]      track_x,
  output logic signed [15:0]      track_y,
  output logic signed [16:0]      yaw_command,
  output logic signed [16:0]      pitch_command
);

  // The front accepts items and classifies them as a seen update, a lost
  // update or a commit. Classified items wait in a short queue so that the
  // input side keeps flowing while the output side is stalled.
  logic          push;
  item_t         push_item;
  logic          pop;
  logic          q_valid;
  item_t         q_item;
  queue_status_t q_status;

  trs_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .now_time          (now_time),
    .target_seen       (target_seen),
    .offset_x          (offset_x),
    .offset_y          (offset_y),
    .yaw_done_pulses   (yaw_done_pulses),
    .yaw_taken         (yaw_taken),
    .pitch_done_pulses (pitch_done_pulses),
    .pitch_taken       (pitch_taken),
    .q_status          (q_status),
    .push              (push),
    .push_item         (push_item)
  );

  trs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_status  (q_status)
  );

  // The back holds the mode machine, the hold timer, the scan axes and the
  // configuration. It carries out one item per cycle unless a waiting result
  // is stalled, and places each result in an output register. Commits never
  // produce a result, so they may be carried out while a result waits.
  trs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mode_now      (mode_now),
    .use_track     (use_track),
    .reset_track   (reset_track),
    .stop_track    (stop_track),
    .track_x       (track_x),
    .track_y       (track_y),
    .yaw_command   (yaw_command),
    .pitch_command (pitch_command)
  );

endmodule

`default_nettype wire

// ===== rtl/trs_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module trs_checker
  import trs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         mode_now,
  input wire logic               use_track,
  input wire logic               reset_track,
  input wire logic               stop_track,
  input wire logic signed [15:0] track_x,
  input wire logic signed [15:0] track_y,
  input wire logic signed [16:0] yaw_command,
  input wire logic signed [16:0] pitch_command
);

  // A stalled result stays offered.
  `CHECK_CLKD(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // Tracking results follow the tracker and carry no scan commands.
  `CHECK_IMPL(a_track_cmd, out_valid && (mode_now == 2'(MODE_TRACK)), use_track && (yaw_command == '0) && (pitch_command == '0), "tracking result carries scan data")

  // Scanning results never drive the tracker.
  `CHECK_IMPL(a_scan_quiet, out_valid && (mode_now == 2'(MODE_SCAN)), !use_track && !reset_track && (track_x == '0) && (track_y == '0), "scanning result drives tracker")

  // The update that enters scanning issues no commands.
  `CHECK_IMPL(a_scan_entry, out_valid && stop_track && (mode_now == 2'(MODE_SCAN)), (yaw_command == '0) && (pitch_command == '0), "scan entry issued commands")

endmodule

bind target_loss_recovery_scanner trs_checker u_trs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .mode_now      (mode_now),
  .use_track     (use_track),
  .reset_track   (reset_track),
  .stop_track    (stop_track),
  .track_x       (track_x),
  .track_y       (track_y),
  .yaw_command   (yaw_command),
  .pitch_command (pitch_command)
);

`default_nettype wire

// ===== sim/tb_target_loss_recovery_scanner.sv =====
`timescale 1ns / 1ps

module tb_target_loss_recovery_scanner;
  import trs_pkg::*;

  // Item kinds on the input channel.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  // An index that names no register; a write to it must leave every setting alone.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Extra wait for a commit item that may still be in the queue when the
  // last result has gone.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT_LIMIT = 20000;
  localparam int PRINT_LIMIT = 100;
  localparam int PHASE_COUNT = 9;
  localparam int ITEMS_PER_PHASE = 128;

  typedef struct packed {
    logic               kind;
    logic [31:0]        now_time;
    logic               target_seen;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [16:0] yaw_done_pulses;
    logic               yaw_taken;
    logic signed [16:0] pitch_done_pulses;
    logic               pitch_taken;
  } gimbal_item_t;

  typedef struct packed {
    mode_t              mode;
    logic               use_track;
    logic               reset_track;
    logic               stop_track;
    logic signed [15:0] track_x;
    logic signed [15:0] track_y;
    logic signed [16:0] yaw_command;
    logic signed [16:0] pitch_command;
  } gimbal_resp_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   reg_index;
    logic [15:0]  reg_value;
    gimbal_item_t item;
    logic         typed;
    gimbal_resp_t want;
  } stim_row_t;

  // Clock, reset and every input of the block start at known values.
  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = 1'b0;
  logic [31:0]        now_time = '0;
  logic               target_seen = 1'b0;
  logic signed [15:0] offset_x = '0;
  logic signed [15:0] offset_y = '0;
  logic signed [16:0] yaw_done_pulses = '0;
  logic               yaw_taken = 1'b0;
  logic signed [16:0] pitch_done_pulses = '0;
  logic               pitch_taken = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         mode_now;
  logic               use_track;
  logic               reset_track;
  logic               stop_track;
  logic signed [15:0] track_x;
  logic signed [15:0] track_y;
  logic signed [16:0] yaw_command;
  logic signed [16:0] pitch_command;

  target_loss_recovery_scanner u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .now_time          (now_time),
    .target_seen       (target_seen),
    .offset_x          (offset_x),
    .offset_y          (offset_y),
    .yaw_done_pulses   (yaw_done_pulses),
    .yaw_taken         (yaw_taken),
    .pitch_done_pulses (pitch_done_pulses),
    .pitch_taken       (pitch_taken),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .mode_now          (mode_now),
    .use_track         (use_track),
    .reset_track       (reset_track),
    .stop_track        (stop_track),
    .track_x           (track_x),
    .track_y           (track_y),
    .yaw_command       (yaw_command),
    .pitch_command     (pitch_command)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 23;
  int recv_idle_pct = 62;
  int error_count = 0;
  int result_count = 0;

  // Responses the block owes, oldest first.
  gimbal_resp_t pending_responses[$];
  gimbal_resp_t last_response = '0;
  stim_row_t    directed_rows[$];

  // Our own copy of the block's settings and mode state.
  logic [15:0] hold_ms, period_ms, yaw_half, yaw_step, pitch_half, pitch_step;
  mode_t       mode_q;
  logic [31:0] lost_at, yaw_timer, pitch_timer;
  logic [31:0] yaw_pos, pitch_pos;
  logic signed [15:0] held_x, held_y;
  logic        yaw_fwd, pitch_fwd, have_history;

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d field %s: got %h, expected %h",
                             result_count, name, got, want));
  endtask

  // One scan step of one axis, worked in wide signed arithmetic: turn round at
  // either edge of the span, then clip the step to what is left to that edge.
  task automatic scan_move(input logic [31:0] pos, input logic [15:0] half,
                           input logic [15:0] step, inout logic fwd,
                           output logic signed [16:0] cmd);
    longint p, h, s, c, r;
    p = longint'($signed(pos));
    h = longint'(half);
    s = longint'(step);
    if (p >= h) begin
      fwd = 1'b0;
    end else if (p <= -h) begin
      fwd = 1'b1;
    end
    if (fwd) begin
      c = s;
      r = h - p;
      if (c > r) c = r;
    end else begin
      c = -s;
      r = -h - p;
      if (c < r) c = r;
    end
    cmd = c[16:0];
  endtask

  // Works out what the block answers to one accepted item, and moves our copy
  // of its state on. Commits never answer; updates always do.
  task automatic compute_gimbal_response(input gimbal_item_t it, output logic produced,
                                         output gimbal_resp_t r);
    logic [31:0] since;
    r = '0;
    r.mode = MODE_TRACK;
    produced = 1'b0;
    if (it.kind == KIND_COMMIT) begin
      // Pulses only count while scanning; elsewhere the commit is dropped.
      if (mode_q == MODE_SCAN) begin
        if (it.yaw_taken) begin
          yaw_pos = yaw_pos + {{15{it.yaw_done_pulses[16]}}, it.yaw_done_pulses};
          yaw_timer = it.now_time;
        end
        if (it.pitch_taken) begin
          pitch_pos = pitch_pos + {{15{it.pitch_done_pulses[16]}}, it.pitch_done_pulses};
          pitch_timer = it.now_time;
        end
      end
    end else begin
      produced = 1'b1;
      if (it.target_seen) begin
        r.reset_track = (mode_q != MODE_TRACK);
        r.stop_track = (mode_q == MODE_SCAN);
        mode_q = MODE_TRACK;
        held_x = it.offset_x;
        held_y = it.offset_y;
        have_history = 1'b1;
        r.mode = MODE_TRACK;
        r.use_track = 1'b1;
        r.track_x = held_x;
        r.track_y = held_y;
      end else begin
        if (mode_q == MODE_TRACK) begin
          mode_q = MODE_PREDICT;
          lost_at = it.now_time;
        end
        if (mode_q == MODE_PREDICT) begin
          since = it.now_time - lost_at;
          if (have_history && since < {16'd0, hold_ms}) begin
            r.mode = MODE_PREDICT;
            r.use_track = 1'b1;
            r.track_x = held_x;
            r.track_y = held_y;
          end else begin
            // Scan starts from the centre, both axes forward, timers restarted.
            mode_q = MODE_SCAN;
            yaw_pos = '0;
            pitch_pos = '0;
            yaw_fwd = 1'b1;
            pitch_fwd = 1'b1;
            yaw_timer = it.now_time;
            pitch_timer = it.now_time;
            r.mode = MODE_SCAN;
            r.stop_track = 1'b1;
          end
        end else begin
          r.mode = MODE_SCAN;
          since = it.now_time - yaw_timer;
          if (since >= {16'd0, period_ms})
            scan_move(yaw_pos, yaw_half, yaw_step, yaw_fwd, r.yaw_command);
          since = it.now_time - pitch_timer;
          if (since >= {16'd0, period_ms})
            scan_move(pitch_pos, pitch_half, pitch_step, pitch_fwd, r.pitch_command);
        end
      end
    end
  endtask

  // Stop sending, then wait for every owed result. With settle set, also let
  // a trailing commit item work its way through before a register write.
  task automatic drain_pending(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PREDICTION_HOLD: hold_ms = value;
      REG_SCAN_PERIOD:     period_ms = value;
      REG_YAW_HALF_SPAN:   yaw_half = value;
      REG_YAW_STEP:        yaw_step = value;
      REG_PITCH_HALF_SPAN: pitch_half = value;
      REG_PITCH_STEP:      pitch_step = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one item, waits until it is taken, and records what it should
  // produce. A typed expectation replaces the predicted one for that item.
  task automatic drive_item(input gimbal_item_t it, input logic typed,
                            input gimbal_resp_t want);
    logic         produced;
    gimbal_resp_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    now_time <= it.now_time;
    target_seen <= it.target_seen;
    offset_x <= it.offset_x;
    offset_y <= it.offset_y;
    yaw_done_pulses <= it.yaw_done_pulses;
    yaw_taken <= it.yaw_taken;
    pitch_done_pulses <= it.pitch_done_pulses;
    pitch_taken <= it.pitch_taken;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_gimbal_response(it, produced, r);
    if (produced) begin
      last_response = r;
      pending_responses.push_back(typed ? want : r);
    end
  endtask

  function automatic gimbal_resp_t resp(input mode_t m, input logic u, input logic rt,
                                        input logic st, input logic signed [15:0] x,
                                        input logic signed [15:0] y);
    gimbal_resp_t r;
    r = '0;
    r.mode = m;
    r.use_track = u;
    r.reset_track = rt;
    r.stop_track = st;
    r.track_x = x;
    r.track_y = y;
    return r;
  endfunction

  task automatic add_reg(input logic [2:0] idx, input logic [15:0] value);
    stim_row_t row;
    row.kind = ROW_REG;
    row.reg_index = idx;
    row.reg_value = value;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_update(input logic [31:0] t, input logic seen,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic typed, input gimbal_resp_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_index = '0;
    row.reg_value = '0;
    row.item = '0;
    row.item.kind = KIND_UPDATE;
    row.item.now_time = t;
    row.item.target_seen = seen;
    row.item.offset_x = x;
    row.item.offset_y = y;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_commit(input logic [31:0] t, input logic signed [16:0] yd,
                            input logic yt, input logic signed [16:0] pd, input logic pt);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_index = '0;
    row.reg_value = '0;
    row.item = '0;
    row.item.kind = KIND_COMMIT;
    row.item.now_time = t;
    row.item.yaw_done_pulses = yd;
    row.item.yaw_taken = yt;
    row.item.pitch_done_pulses = pd;
    row.item.pitch_taken = pt;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick_setting(input int phase, input int usual_max);
    int roll;
    roll = $urandom_range(0, 19);
    if (phase == 0) return 16'd0;
    if (phase == 1) return 16'hFFFF;
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom_range(0, usual_max));
  endfunction

  function automatic logic signed [16:0] random_pulses();
    return 17'(int'($urandom_range(0, 131070)) - 65535);
  endfunction

  // Receiving side: check each result taken, then choose the next stall.
  initial begin
    gimbal_resp_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_responses.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = pending_responses.pop_front();
          check_field("mode_now", 32'(mode_now), 32'(want.mode));
          check_field("use_track", 32'(use_track), 32'(want.use_track));
          check_field("reset_track", 32'(reset_track), 32'(want.reset_track));
          check_field("stop_track", 32'(stop_track), 32'(want.stop_track));
          check_field("track_x", 32'(track_x), 32'(want.track_x));
          check_field("track_y", 32'(track_y), 32'(want.track_y));
          check_field("yaw_command", 32'(yaw_command), 32'(want.yaw_command));
          check_field("pitch_command", 32'(pitch_command), 32'(want.pitch_command));
        end
        result_count++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Sending side: reset, the directed table, then random phases.
  initial begin
    gimbal_item_t it;
    logic [31:0]  now_ms;
    int           lost_left;
    int           effective;
    int           sent;
    int           waited;
    bit           commit_due;

    hold_ms = '0;
    period_ms = '0;
    yaw_half = '0;
    yaw_step = '0;
    pitch_half = '0;
    pitch_step = '0;
    mode_q = MODE_TRACK;
    lost_at = '0;
    yaw_timer = '0;
    pitch_timer = '0;
    yaw_pos = '0;
    pitch_pos = '0;
    held_x = '0;
    held_y = '0;
    yaw_fwd = 1'b1;
    pitch_fwd = 1'b1;
    have_history = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A loss before any detection has been seen goes straight to scanning,
    // even though the hold time is not zero.
    add_reg(REG_PREDICTION_HOLD, 16'd100);
    add_update(32'd10, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0));
    // Re-acquiring from scanning raises both reset and stop; offsets at the extremes.
    add_update(32'd11, 1'b1, 16'sh7FFF, 16'sh8000, 1'b1,
               resp(MODE_TRACK, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000));
    add_update(32'd12, 1'b1, 16'sh8000, 16'sh7FFF, 1'b1,
               resp(MODE_TRACK, 1'b1, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF));
    // Commits while tracking or predicting are dropped.
    add_commit(32'd13, 17'sd65535, 1'b1, -17'sd65535, 1'b1);
    add_update(32'd1000, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_PREDICT, 1'b1, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF));
    add_commit(32'd1001, -17'sd65535, 1'b1, 17'sd65535, 1'b1);
    add_update(32'd1099, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_PREDICT, 1'b1, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF));
    // The hold runs out exactly at the hold time.
    add_update(32'd1100, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0));
    // A short yaw span to walk into the edge; pitch has a zero span.
    add_reg(REG_SCAN_PERIOD, 16'd3);
    add_reg(REG_YAW_HALF_SPAN, 16'd10);
    add_reg(REG_YAW_STEP, 16'd4);
    add_reg(REG_PITCH_HALF_SPAN, 16'd0);
    add_reg(REG_PITCH_STEP, 16'd7);
    add_update(32'd1101, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0));
    add_update(32'd1103, 1'b0, 16'sd0, 16'sd0, 1'b0, '0);
    add_commit(32'd1103, 17'sd4, 1'b1, 17'sd0, 1'b0);
    add_update(32'd1106, 1'b0, 16'sd0, 16'sd0, 1'b0, '0);
    add_commit(32'd1106, 17'sd4, 1'b1, 17'sd0, 1'b0);
    // This step is clipped short by the edge, and the next one turns round.
    add_update(32'd1109, 1'b0, 16'sd0, 16'sd0, 1'b0, '0);
    add_commit(32'd1109, 17'sd2, 1'b1, 17'sd0, 1'b0);
    add_update(32'd1112, 1'b0, 16'sd0, 16'sd0, 1'b0, '0);
    add_commit(32'd1112, -17'sd65535, 1'b1, 17'sd65535, 1'b1);
    // Every setting at its top value; a write to an unused index changes nothing.
    add_reg(REG_PREDICTION_HOLD, 16'hFFFF);
    add_reg(REG_SCAN_PERIOD, 16'hFFFF);
    add_reg(REG_YAW_HALF_SPAN, 16'hFFFF);
    add_reg(REG_YAW_STEP, 16'hFFFF);
    add_reg(REG_PITCH_HALF_SPAN, 16'hFFFF);
    add_reg(REG_PITCH_STEP, 16'hFFFF);
    add_reg(REG_UNUSED, 16'hFFFF);
    add_update(32'd1200, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0));
    add_update(32'd66647, 1'b0, 16'sd0, 16'sd0, 1'b0, '0);
    // Time wraps round while predicting.
    add_update(32'hFFFF_FFF0, 1'b1, 16'sd1, -16'sd1, 1'b1,
               resp(MODE_TRACK, 1'b1, 1'b1, 1'b1, 16'sd1, -16'sd1));
    add_update(32'hFFFF_FFF8, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_PREDICT, 1'b1, 1'b0, 1'b0, 16'sd1, -16'sd1));
    add_update(32'h0000_0010, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_PREDICT, 1'b1, 1'b0, 1'b0, 16'sd1, -16'sd1));
    // With no hold, predicting ends at once, and a loss from tracking scans at once.
    add_reg(REG_PREDICTION_HOLD, 16'd0);
    add_update(32'h0000_0020, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0));
    add_update(32'h0000_0021, 1'b1, 16'sd5, 16'sd6, 1'b1,
               resp(MODE_TRACK, 1'b1, 1'b1, 1'b1, 16'sd5, 16'sd6));
    add_update(32'h0000_0022, 1'b0, 16'sd0, 16'sd0, 1'b1,
               resp(MODE_SCAN, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_pending(1'b1);
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases. Most items follow the life of a real gimbal: runs of
    // detections, losses long enough to reach the scan, and a commit after
    // most scan updates carrying the pulses just asked for. A few items are
    // pure noise.
    now_ms = 32'd5000;
    lost_left = 0;
    commit_due = 1'b0;
    sent = 0;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_pending(1'b1);
      write_register(REG_PREDICTION_HOLD, pick_setting(phase, 40));
      write_register(REG_SCAN_PERIOD, pick_setting(phase, 8));
      write_register(REG_YAW_HALF_SPAN, pick_setting(phase, 60));
      write_register(REG_YAW_STEP, pick_setting(phase, 25));
      write_register(REG_PITCH_HALF_SPAN, pick_setting(phase, 60));
      write_register(REG_PITCH_STEP, pick_setting(phase, 25));
      // One phase runs across the wrap of the millisecond clock.
      if (phase == 4) now_ms = 32'hFFFF_FF00;

      effective = 0;
      while (effective < ITEMS_PER_PHASE) begin
        // Fill every field at random so that the unused ones carry junk too.
        it.kind = KIND_UPDATE;
        it.target_seen = 1'($urandom);
        it.offset_x = 16'($urandom);
        it.offset_y = 16'($urandom);
        it.yaw_done_pulses = random_pulses();
        it.yaw_taken = 1'($urandom);
        it.pitch_done_pulses = random_pulses();
        it.pitch_taken = 1'($urandom);
        case ($urandom_range(0, 99)) inside
          [0:69]:  now_ms = now_ms + $urandom_range(0, 6);
          [70:89]: now_ms = now_ms + $urandom_range(0, 60);
          [90:97]: now_ms = now_ms + $urandom_range(0, 70000);
          default: now_ms = $urandom;
        endcase
        it.now_time = now_ms;

        if ($urandom_range(0, 99) < 5) begin
          it.kind = 1'($urandom);
        end else if (mode_q == MODE_SCAN && commit_due) begin
          it.kind = KIND_COMMIT;
          if ($urandom_range(0, 9) != 0) begin
            it.yaw_done_pulses = last_response.yaw_command;
            it.pitch_done_pulses = last_response.pitch_command;
            it.yaw_taken = (last_response.yaw_command != 0) ?
                           ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
            it.pitch_taken = (last_response.pitch_command != 0) ?
                             ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
          end
        end else if (lost_left > 0) begin
          it.target_seen = 1'b0;
          lost_left--;
        end else begin
          it.target_seen = 1'b1;
          if ($urandom_range(0, 9) == 0) lost_left = $urandom_range(2, 60);
        end

        // Commits outside scanning are dropped by the block and are not counted.
        if (it.kind == KIND_UPDATE || mode_q == MODE_SCAN) effective++;
        drive_item(it, 1'b0, '0);
        commit_due = (it.kind == KIND_UPDATE) && (mode_q == MODE_SCAN) &&
                     ($urandom_range(0, 3) != 0);
        sent++;
        // Now and then the sender waits until every owed result has come out.
        if (sent % 50 == 49) drain_pending(1'b0);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_responses.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_responses.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run needs.
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/trs_pkg.sv
rtl/trs_front.sv
rtl/trs_queue.sv
rtl/trs_back.sv
rtl/target_loss_recovery_scanner.sv
rtl/trs_checker.sv
sim/tb_target_loss_recovery_scanner.sv
